// File: hw/rtl/mtg_pkg.sv
// Shared types, constants and functions of the MT19937 generator.
package mtg_pkg;

	localparam int WORD_W = 32;
	localparam int STATE_WORDS_DEF = 624;
	localparam int TWIST_OFFSET_DEF = 397;

	typedef logic [WORD_W-1:0] word_t;

	localparam logic MODE_RESEED = 1'b0;
	localparam logic MODE_DRAW = 1'b1;

	localparam word_t SEED_ZERO_SUB = 32'd4357;
	localparam word_t SEED_DEFAULT = 32'd5489;
	localparam word_t INIT_MULT = 32'd1812433253;
	localparam word_t TWIST_MATRIX = 32'h9908_b0df;
	localparam word_t TEMPER_B = 32'h9d2c_5680;
	localparam word_t TEMPER_C = 32'hefc6_0000;

	// Status and shift request that the seeder hands to the cell chain.
	typedef struct packed {
		logic busy;
		logic shift;
		word_t word;
	} seed_stat_t;

	function automatic word_t twist(input word_t head, input word_t next, input word_t far);
		word_t y;
		word_t mag;
		y = {head[WORD_W-1], next[WORD_W-2:0]};
		mag = y[0] ? TWIST_MATRIX : '0;
		return far ^ (y >> 1) ^ mag;
	endfunction

	function automatic word_t temper(input word_t x);
		word_t y;
		y = x;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

// File: hw/rtl/mtg_if.sv
// Handshake interfaces for the command and result channels.
interface mtg_cmd_if;
	logic valid;
	logic ready;
	logic mode;
	logic [mtg_pkg::WORD_W-1:0] seed_value;

	modport source (output valid, mode, seed_value, input ready);
	modport sink (input valid, mode, seed_value, output ready);
endinterface

interface mtg_result_if;
	logic valid;
	logic ready;
	logic [mtg_pkg::WORD_W-1:0] random_word;

	modport source (output valid, random_word, input ready);
	modport sink (input valid, random_word, output ready);
endinterface

// File: hw/rtl/mtg_cell.sv
// One state word of the generator, loaded from its right neighbor on a shift.
module mtg_cell (
	input  logic          clk,
	input  logic          shift,
	input  mtg_pkg::word_t d,
	output mtg_pkg::word_t q
);

	mtg_pkg::word_t word_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			word_q <= d;
		end
	end

	assign q = word_q;

endmodule

// File: hw/rtl/mtg_seeder.sv
// Seeding sequencer: produces the initialization recurrence one word per cycle.
module mtg_seeder #(
	parameter int STATE_WORDS = mtg_pkg::STATE_WORDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  mtg_pkg::word_t      start_word,
	input  mtg_pkg::word_t      tail,
	output mtg_pkg::seed_stat_t stat
);

	localparam int IDX_W = $clog2(STATE_WORDS);

	logic busy_q;
	logic [IDX_W-1:0] idx_q;
	mtg_pkg::word_t mix;
	mtg_pkg::word_t prod;

	// The tail cell holds the word entered last, so it is the previous term.
	assign mix = tail ^ (tail >> 30);
	assign prod = mtg_pkg::INIT_MULT * mix;

	always_comb begin
		stat.busy = busy_q;
		stat.shift = start || busy_q;
		stat.word = busy_q ? (prod + mtg_pkg::WORD_W'(idx_q)) : start_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q <= IDX_W'(1);
		end else if (busy_q) begin
			idx_q <= idx_q + IDX_W'(1);
			if (idx_q == IDX_W'(STATE_WORDS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

// File: hw/rtl/mersenne_twister_generator.sv
// Top level of the MT19937 generator: cell chain, seeder and result register.
//
// Requests arrive on cmd: mode selects a reseed (seed_value, zero means 4357)
// or a draw of one tempered 32-bit word, which leaves on result.
// The 624 state words sit in a row of cells that shift toward cell 0. A draw
// computes the next word from cells 0, 1 and 397, shifts it in at the tail
// and tempers it into the result register, so the twist runs one word per draw.
// A draw's result is registered at the accepting edge and is valid in the
// cycle after; draws are taken one per cycle while the result is being taken.
// A reseed enters the seed at the accepting edge, then the seeder's
// multiply-add loop enters one word per cycle until all 624 state words are
// loaded, with cmd.ready low throughout.
// A draw before any seed first seeds with 5489, and its result is drawn once
// the seeder is done and the result slot is free.
// Reset leaves the generator unseeded and the result register empty. While
// result is stalled with a word waiting, cmd.ready is low and the word holds.
module mersenne_twister_generator #(
	parameter int STATE_WORDS = mtg_pkg::STATE_WORDS_DEF,
	parameter int TWIST_OFFSET = mtg_pkg::TWIST_OFFSET_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	mtg_cmd_if.sink      cmd,
	mtg_result_if.source result
);

	mtg_pkg::word_t cell_q [STATE_WORDS];
	mtg_pkg::word_t chain_in;
	mtg_pkg::word_t next_word;
	mtg_pkg::word_t start_word;
	mtg_pkg::word_t word_q;
	mtg_pkg::seed_stat_t seed_stat;
	logic chain_shift;
	logic out_valid_q;
	logic seeded_q;
	logic pend_q;
	logic slot_free;
	logic accept;
	logic seed_start;
	logic draw_fire;

	assign slot_free = !out_valid_q || result.ready;
	assign cmd.ready = !seed_stat.busy && !pend_q && slot_free;
	assign accept = cmd.valid && cmd.ready;

	// A draw before any seed starts a default seeding and waits for it.
	assign seed_start = accept && ((cmd.mode == mtg_pkg::MODE_RESEED) || !seeded_q);
	assign draw_fire = (accept && (cmd.mode == mtg_pkg::MODE_DRAW) && seeded_q)
		|| (pend_q && !seed_stat.busy && slot_free);

	always_comb begin
		if (cmd.mode == mtg_pkg::MODE_DRAW) begin
			start_word = mtg_pkg::SEED_DEFAULT;
		end else if (cmd.seed_value == '0) begin
			start_word = mtg_pkg::SEED_ZERO_SUB;
		end else begin
			start_word = cmd.seed_value;
		end
	end

	assign next_word = mtg_pkg::twist(cell_q[0], cell_q[1], cell_q[TWIST_OFFSET]);
	assign chain_shift = seed_stat.shift || draw_fire;
	assign chain_in = seed_stat.shift ? seed_stat.word : next_word;

	mtg_seeder #(
		.STATE_WORDS(STATE_WORDS)
	) u_seeder (
		.clk(clk),
		.arst_n(arst_n),
		.start(seed_start),
		.start_word(start_word),
		.tail(cell_q[STATE_WORDS-1]),
		.stat(seed_stat)
	);

	for (genvar i = 0; i < STATE_WORDS; i++) begin : g_cell
		if (i == STATE_WORDS - 1) begin : g_tail
			mtg_cell u_cell (.clk(clk), .shift(chain_shift), .d(chain_in), .q(cell_q[i]));
		end else begin : g_body
			mtg_cell u_cell (.clk(clk), .shift(chain_shift), .d(cell_q[i+1]), .q(cell_q[i]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			seeded_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			if (seed_start) begin
				seeded_q <= 1'b1;
				pend_q <= (cmd.mode == mtg_pkg::MODE_DRAW);
			end else if (draw_fire) begin
				pend_q <= 1'b0;
			end
			if (draw_fire) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (draw_fire) begin
			word_q <= mtg_pkg::temper(next_word);
		end
	end

	assign result.valid = out_valid_q;
	assign result.random_word = word_q;

`ifndef SYNTHESIS
	a_reseed_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd.mode == mtg_pkg::MODE_RESEED)) |=> seed_stat.busy)
		else $error("reseed request did not start the seeder");

	a_draw_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd.mode == mtg_pkg::MODE_DRAW) && seeded_q) |=> out_valid_q)
		else $error("draw request on a seeded generator gave no result");

	a_seeded_after: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(seed_stat.busy) |-> seeded_q)
		else $error("seeding finished without the seeded flag");
`endif

endmodule

// File: bench/tb_mersenne_twister_generator.sv
// Self-checking testbench for the MT19937 generator with a scoreboard.
module tb_mersenne_twister_generator;

	localparam int unsigned IDLE_LIMIT = 5000;
	localparam int unsigned TAIL_CYCLES = 700;

	// Keeps a copy of the generator state and the queue of words still owed by the block.
	class mt_scoreboard;
		localparam int unsigned N_WORDS = 624;
		localparam int unsigned FAR_OFFSET = 397;
		localparam mtg_pkg::word_t ZERO_SEED_SUB = 32'd4357;
		localparam mtg_pkg::word_t BOOT_SEED = 32'd5489;
		localparam mtg_pkg::word_t FILL_MULT = 32'd1812433253;
		localparam mtg_pkg::word_t MATRIX_A = 32'h9908_b0df;
		localparam mtg_pkg::word_t MASK_B = 32'h9d2c_5680;
		localparam mtg_pkg::word_t MASK_C = 32'hefc6_0000;

		mtg_pkg::word_t words[N_WORDS];
		int unsigned next_idx;
		mtg_pkg::word_t owed_words[$];
		int unsigned mismatches;
		int unsigned words_checked;
		int unsigned draws;
		int unsigned reseeds;
		int unsigned zero_seeds;
		int unsigned refreshes;

		function new();
			next_idx = N_WORDS + 1;
			mismatches = 0;
			words_checked = 0;
			draws = 0;
			reseeds = 0;
			zero_seeds = 0;
			refreshes = 0;
		endfunction

		function void load(mtg_pkg::word_t seed);
			words[0] = seed;
			for (int unsigned i = 1; i < N_WORDS; i++)
				words[i] = FILL_MULT * (words[i-1] ^ (words[i-1] >> 30))
					+ mtg_pkg::word_t'(i);
			next_idx = N_WORDS;
		endfunction

		function int unsigned pending();
			return owed_words.size();
		endfunction

		function void flag(string what, mtg_pkg::word_t want, mtg_pkg::word_t got);
			mismatches++;
			if (mismatches <= 10)
				$display("MISMATCH %s: expected %08h, got %08h", what, want, got);
		endfunction

		function void note_request(logic op, mtg_pkg::word_t seed);
			mtg_pkg::word_t y;
			mtg_pkg::word_t mag;
			if (op == mtg_pkg::MODE_RESEED) begin
				reseeds++;
				if (seed == '0)
					zero_seeds++;
				load(seed == '0 ? ZERO_SEED_SUB : seed);
				return;
			end
			draws++;
			if (next_idx >= N_WORDS) begin
				if (next_idx == N_WORDS + 1)
					load(BOOT_SEED);
				for (int unsigned k = 0; k < N_WORDS; k++) begin
					y = {words[k][31], words[(k + 1) % N_WORDS][30:0]};
					mag = y[0] ? MATRIX_A : '0;
					words[k] = words[(k + FAR_OFFSET) % N_WORDS] ^ (y >> 1) ^ mag;
				end
				next_idx = 0;
				refreshes++;
			end
			y = words[next_idx];
			next_idx++;
			y = y ^ (y >> 11);
			y = y ^ ((y << 7) & MASK_B);
			y = y ^ ((y << 15) & MASK_C);
			y = y ^ (y >> 18);
			owed_words.push_back(y);
		endfunction

		function void check_word(mtg_pkg::word_t got);
			mtg_pkg::word_t want;
			if (owed_words.size() == 0) begin
				flag("word with no draw outstanding", '0, got);
				return;
			end
			want = owed_words.pop_front();
			words_checked++;
			if (got !== want)
				flag("random_word", want, got);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	mt_scoreboard sb;

	mtg_cmd_if cmd_bus();
	mtg_result_if result_bus();

	mersenne_twister_generator u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_bus),
		.result(result_bus)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Results are checked before the request of the same edge is noted, so a stray
	// word can never be matched against a draw that was only just taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_bus.valid && result_bus.ready)
				sb.check_word(result_bus.random_word);
			if (cmd_bus.valid && cmd_bus.ready)
				sb.note_request(cmd_bus.mode, cmd_bus.seed_value);
		end
	end

	initial begin : watchdog
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((cmd_bus.valid && cmd_bus.ready) || (result_bus.valid && result_bus.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
		$display("mersenne_twister_generator verification failed");
		$finish;
	end

	task automatic send_request(logic op, mtg_pkg::word_t seed);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_bus.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_bus.valid <= 1'b1;
		cmd_bus.mode <= op;
		cmd_bus.seed_value <= seed;
		@(posedge clk);
		while (!cmd_bus.ready)
			@(posedge clk);
	endtask

	// Holds the request channel quiet until every owed word has come back.
	task automatic drain();
		cmd_bus.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(int unsigned count, int unsigned reseed_odds);
		logic op;
		mtg_pkg::word_t seed;
		for (int unsigned n = 0; n < count; n++) begin
			op = mtg_pkg::MODE_DRAW;
			seed = $urandom;
			if (reseed_odds != 0 && $urandom_range(reseed_odds - 1) == 0) begin
				op = mtg_pkg::MODE_RESEED;
				if ($urandom_range(7) == 0)
					seed = '0;
			end
			send_request(op, seed);
			if (reseed_odds != 0 && $urandom_range(149) == 0)
				drain();
		end
		drain();
	endtask

	initial begin
		sb = new();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n <= 1'b0;
		cmd_bus.valid <= 1'b0;
		cmd_bus.mode <= mtg_pkg::MODE_RESEED;
		cmd_bus.seed_value <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A draw straight out of reset must seed itself with the default seed.
		send_request(mtg_pkg::MODE_DRAW, 32'h0000_0000);
		send_request(mtg_pkg::MODE_DRAW, 32'hffff_ffff);
		send_request(mtg_pkg::MODE_DRAW, 32'h1234_5678);
		drain();
		send_request(mtg_pkg::MODE_RESEED, 32'h0000_0000);
		send_request(mtg_pkg::MODE_DRAW, 32'h0000_0000);
		send_request(mtg_pkg::MODE_DRAW, 32'hffff_ffff);
		send_request(mtg_pkg::MODE_RESEED, 32'hffff_ffff);
		send_request(mtg_pkg::MODE_DRAW, 32'h5555_5555);
		send_request(mtg_pkg::MODE_RESEED, 32'h0000_0001);
		send_request(mtg_pkg::MODE_RESEED, 32'h8000_0000);
		send_request(mtg_pkg::MODE_DRAW, 32'haaaa_aaaa);
		send_request(mtg_pkg::MODE_DRAW, 32'h0000_0000);
		send_request(mtg_pkg::MODE_RESEED, 32'h7fff_ffff);
		send_request(mtg_pkg::MODE_DRAW, 32'h0000_0000);
		send_request(mtg_pkg::MODE_RESEED, 32'd5489);
		send_request(mtg_pkg::MODE_DRAW, 32'h8000_0000);
		send_request(mtg_pkg::MODE_DRAW, 32'h7fff_ffff);
		send_request(mtg_pkg::MODE_RESEED, 32'h0000_0001);
		send_request(mtg_pkg::MODE_DRAW, 32'h0000_0001);
		drain();

		// One long run of draws so that the state is refreshed at least once.
		run_phase(700, 0);
		send_idle_pct = 59;
		recv_stall_pct = 0;
		run_phase(125, 16);
		send_idle_pct = 0;
		recv_stall_pct = 59;
		run_phase(125, 16);
		send_idle_pct = 7;
		recv_stall_pct = 7;
		run_phase(125, 16);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.pending() != 0) begin
			sb.mismatches += sb.pending();
			$display("%0d expected words never arrived", sb.pending());
		end
		$display("Run covered %0d draws, %0d reseeds (%0d zero seeds), %0d state refreshes,",
			sb.draws, sb.reseeds, sb.zero_seeds, sb.refreshes);
		$display("with sender gaps and result stalls; %0d words checked, %0d mismatches.",
			sb.words_checked, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("mersenne_twister_generator verification clean");
		end else begin
			$display("mersenne_twister_generator verification failed");
		end
		$finish;
	end

endmodule
